// ===== src/srtf_pkg.sv =====
// shared types and constants for the srtf scheduler
// depends on nothing; every other file of the block uses it
`timescale 1ns / 1ps

package srtf_pkg;

    localparam int ID_W          = 8;
    localparam int REM_W         = 16;
    localparam int LVL_W         = 4;
    localparam int TIME_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int SLOTS_DEFAULT = 16;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_PREEMPTED = 2'd0,
        STATUS_COMPLETED = 2'd1,
        STATUS_REJECTED  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_LOAD = 2'd1,
        CMD_RUN  = 2'd2
    } cmd_kind_t;

    // broadcast from the controller to every cell, the slot index travels beside it
    typedef struct packed {
        cmd_kind_t         kind;
        logic [ID_W-1:0]   id;
        logic [REM_W-1:0]  rem;
        logic [LVL_W-1:0]  lvl;
    } cmd_t;

    // search wave handed from cell to cell, slot indexes travel beside it
    typedef struct packed {
        logic              free_found;
        logic              best_found;
        logic [ID_W-1:0]   best_id;
        logic [REM_W-1:0]  best_rem;
        logic [LVL_W-1:0]  best_lvl;
    } wave_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] seg_start;
        logic [TIME_W-1:0] seg_end;
        status_t           status;
        logic              last;
    } beat_t;

endpackage

// ===== src/srtf_if.sv =====
// valid/ready channel interfaces for job requests and segment results
// depends on srtf_pkg for field widths
`timescale 1ns / 1ps

interface srtf_req_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [srtf_pkg::ID_W-1:0]   job_id;
    logic [srtf_pkg::REM_W-1:0]  burst;
    logic [srtf_pkg::LVL_W-1:0]  priority_level;

    modport source (output valid, operation, job_id, burst, priority_level, input ready);
    modport sink   (input valid, operation, job_id, burst, priority_level, output ready);
endinterface

interface srtf_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [srtf_pkg::ID_W-1:0]    job_id_out;
    logic [srtf_pkg::TIME_W-1:0]  segment_start;
    logic [srtf_pkg::TIME_W-1:0]  segment_end;
    logic [srtf_pkg::STATUS_W-1:0] status;
    logic                         last;

    modport source (output valid, job_id_out, segment_start, segment_end, status, last,
                    input ready);
    modport sink   (input valid, job_id_out, segment_start, segment_end, status, last,
                    output ready);
endinterface

// ===== src/srtf_cell.sv =====
// one ready-table slot plus its stage of the search wave
// depends on srtf_pkg
`timescale 1ns / 1ps

module srtf_cell #(
    parameter int READY_SLOTS = srtf_pkg::SLOTS_DEFAULT,
    parameter int INDEX       = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  srtf_pkg::cmd_t                 cmd,
    input  logic [$clog2(READY_SLOTS)-1:0] cmd_slot,
    input  srtf_pkg::wave_t                wave_in,
    input  logic [$clog2(READY_SLOTS)-1:0] free_in,
    input  logic [$clog2(READY_SLOTS)-1:0] best_in,
    output srtf_pkg::wave_t                wave_out,
    output logic [$clog2(READY_SLOTS)-1:0] free_out,
    output logic [$clog2(READY_SLOTS)-1:0] best_out
);

    localparam int SW = $clog2(READY_SLOTS);
    localparam logic [SW-1:0] MY_SLOT = SW'(INDEX);

    logic                        valid_reg;
    logic [srtf_pkg::ID_W-1:0]   id_reg;
    logic [srtf_pkg::REM_W-1:0]  rem_reg;
    logic [srtf_pkg::LVL_W-1:0]  lvl_reg;

    srtf_pkg::wave_t  wave_reg, wave_next;
    logic [SW-1:0]    free_reg, free_next;
    logic [SW-1:0]    best_reg, best_next;

    logic hit;
    logic take_best;
    logic take_free;

    assign hit = (cmd_slot == MY_SLOT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (hit)
        begin
            unique case (cmd.kind)
                srtf_pkg::CMD_LOAD: valid_reg <= 1'b1;
                srtf_pkg::CMD_RUN:  valid_reg <= (cmd.rem != '0);
                default:            valid_reg <= valid_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit && cmd.kind == srtf_pkg::CMD_LOAD)
        begin
            id_reg  <= cmd.id;
            rem_reg <= cmd.rem;
            lvl_reg <= cmd.lvl;
        end
        else if (hit && cmd.kind == srtf_pkg::CMD_RUN)
        begin
            rem_reg <= cmd.rem;
        end
    end

    // strict compares keep the earlier slot on a full tie
    assign take_best = valid_reg && (!wave_in.best_found ||
                                     rem_reg < wave_in.best_rem ||
                                     (rem_reg == wave_in.best_rem &&
                                      lvl_reg < wave_in.best_lvl));
    assign take_free = !valid_reg && !wave_in.free_found;

    always_comb
    begin
        wave_next = wave_in;
        free_next = free_in;
        best_next = best_in;
        if (take_free)
        begin
            wave_next.free_found = 1'b1;
            free_next            = MY_SLOT;
        end
        if (take_best)
        begin
            wave_next.best_found = 1'b1;
            wave_next.best_id    = id_reg;
            wave_next.best_rem   = rem_reg;
            wave_next.best_lvl   = lvl_reg;
            best_next            = MY_SLOT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg <= '0;
            free_reg <= '0;
            best_reg <= '0;
        end
        else
        begin
            wave_reg <= wave_next;
            free_reg <= free_next;
            best_reg <= best_next;
        end
    end

    assign wave_out = wave_reg;
    assign free_out = free_reg;
    assign best_out = best_reg;

endmodule

// ===== src/srtf_chain.sv =====
// row of slot cells, seeded with an empty wave at the head
// depends on srtf_pkg and srtf_cell
`timescale 1ns / 1ps

module srtf_chain #(
    parameter int READY_SLOTS = srtf_pkg::SLOTS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  srtf_pkg::cmd_t                 cmd,
    input  logic [$clog2(READY_SLOTS)-1:0] cmd_slot,
    output srtf_pkg::wave_t                wave,
    output logic [$clog2(READY_SLOTS)-1:0] free_slot,
    output logic [$clog2(READY_SLOTS)-1:0] best_slot
);

    localparam int SW = $clog2(READY_SLOTS);

    srtf_pkg::wave_t wave_link [READY_SLOTS+1];
    logic [SW-1:0]   free_link [READY_SLOTS+1];
    logic [SW-1:0]   best_link [READY_SLOTS+1];

    assign wave_link[0] = '0;
    assign free_link[0] = '0;
    assign best_link[0] = '0;

    for (genvar i = 0; i < READY_SLOTS; i++)
    begin : g_cell
        srtf_cell #(
            .READY_SLOTS (READY_SLOTS),
            .INDEX       (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .cmd_slot (cmd_slot),
            .wave_in  (wave_link[i]),
            .free_in  (free_link[i]),
            .best_in  (best_link[i]),
            .wave_out (wave_link[i+1]),
            .free_out (free_link[i+1]),
            .best_out (best_link[i+1])
        );
    end

    assign wave      = wave_link[READY_SLOTS];
    assign free_slot = free_link[READY_SLOTS];
    assign best_slot = best_link[READY_SLOTS];

endmodule

// ===== src/srtf_preemptive_scheduler_core.sv =====
// srtf preemptive scheduler: request/result channels, control sequencer, result register
// depends on srtf_pkg, srtf_if and srtf_chain
// flow: an item goes through accept, the wave through the cell row and decide, then hands
// any result beats (one or two) to the result register
// a new request is taken only once the block is back in idle after its last result beat;
// the search wave crosses one cell per cycle
// reset: slot valid bits, running job, time and the result valid bit clear at once, no sweep
`timescale 1ns / 1ps

module srtf_preemptive_scheduler_core #(
    parameter int READY_SLOTS = srtf_pkg::SLOTS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    srtf_req_if.sink       req,
    srtf_rsp_if.source     rsp
);

    localparam int SW = $clog2(READY_SLOTS);
    localparam logic [SW-1:0] LAST_CELL = SW'(READY_SLOTS - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SWEEP  = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // latched request beat
    logic                        op_reg;
    logic [srtf_pkg::ID_W-1:0]   id_reg;
    logic [srtf_pkg::REM_W-1:0]  burst_reg;
    logic [srtf_pkg::LVL_W-1:0]  lvl_reg;

    // wave settling counter, one step per cell
    logic [SW-1:0] cnt_reg, cnt_next;

    // scheduler state outside the table
    logic                        run_valid_reg, run_valid_next;
    logic [SW-1:0]               run_slot_reg, run_slot_next;
    logic [srtf_pkg::ID_W-1:0]   run_id_reg, run_id_next;
    logic [srtf_pkg::TIME_W-1:0] run_start_reg, run_start_next;
    logic [srtf_pkg::TIME_W-1:0] now_reg, now_next;

    // pending result beats of the current item
    srtf_pkg::beat_t pend0_reg, pend0_next;
    srtf_pkg::beat_t pend1_reg, pend1_next;
    logic            two_reg, two_next;
    logic            idx_reg, idx_next;

    // result register in front of the sink
    srtf_pkg::beat_t out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    // cell row
    srtf_pkg::cmd_t  cmd;
    logic [SW-1:0]   cmd_slot;
    srtf_pkg::wave_t wave;
    logic [SW-1:0]   free_slot;
    logic [SW-1:0]   best_slot;

    // decide-time helpers
    logic                        switch_job;
    logic                        preempt;
    logic [srtf_pkg::REM_W-1:0]  new_rem;
    logic                        done;
    logic [srtf_pkg::TIME_W-1:0] now_plus;
    srtf_pkg::beat_t             beat_pre;
    srtf_pkg::beat_t             beat_done;
    srtf_pkg::beat_t             beat_rej;
    logic                        push;

    srtf_chain #(
        .READY_SLOTS (READY_SLOTS)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_slot  (cmd_slot),
        .wave      (wave),
        .free_slot (free_slot),
        .best_slot (best_slot)
    );

    assign req.ready = (state_reg == ST_IDLE);

    // chosen job bookkeeping; remaining time stops at zero
    assign switch_job = !run_valid_reg || (run_slot_reg != best_slot);
    assign preempt    = switch_job && run_valid_reg;
    assign new_rem    = (wave.best_rem == '0) ? '0 : wave.best_rem - 1'b1;
    assign done       = (new_rem == '0);
    assign now_plus   = now_reg + 1'b1;

    always_comb
    begin
        beat_pre.id        = run_id_reg;
        beat_pre.seg_start = run_start_reg;
        beat_pre.seg_end   = now_reg;
        beat_pre.status    = srtf_pkg::STATUS_PREEMPTED;
        beat_pre.last      = !done;

        beat_done.id        = wave.best_id;
        beat_done.seg_start = switch_job ? now_reg : run_start_reg;
        beat_done.seg_end   = now_plus;
        beat_done.status    = srtf_pkg::STATUS_COMPLETED;
        beat_done.last      = 1'b1;

        beat_rej.id        = id_reg;
        beat_rej.seg_start = now_reg;
        beat_rej.seg_end   = now_reg;
        beat_rej.status    = srtf_pkg::STATUS_REJECTED;
        beat_rej.last      = 1'b1;
    end

    // result register takes a beat when empty or when its beat leaves this cycle
    assign push = (state_reg == ST_EMIT) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        run_valid_next = run_valid_reg;
        run_slot_next  = run_slot_reg;
        run_id_next    = run_id_reg;
        run_start_next = run_start_reg;
        now_next       = now_reg;
        pend0_next     = pend0_reg;
        pend1_next     = pend1_reg;
        two_next       = two_reg;
        idx_next       = idx_reg;
        cmd            = '0;
        cmd.kind       = srtf_pkg::CMD_NONE;
        cmd_slot       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cnt_next   = '0;
                    state_next = ST_SWEEP;
                end
            end

            ST_SWEEP:
            begin
                // the table has been still since before accept, so after one pass
                // per cell the tail of the row holds the answer
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                idx_next = 1'b0;
                two_next = 1'b0;
                if (!op_reg)
                begin
                    // arrival
                    if (wave.free_found)
                    begin
                        cmd.kind   = srtf_pkg::CMD_LOAD;
                        cmd.id     = id_reg;
                        cmd.rem    = burst_reg;
                        cmd.lvl    = lvl_reg;
                        cmd_slot   = free_slot;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pend0_next = beat_rej;
                        state_next = ST_EMIT;
                    end
                end
                else if (!wave.best_found)
                begin
                    // idle tick
                    now_next   = now_plus;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.kind = srtf_pkg::CMD_RUN;
                    cmd.rem  = new_rem;
                    cmd_slot = best_slot;
                    if (switch_job)
                    begin
                        run_slot_next  = best_slot;
                        run_id_next    = wave.best_id;
                        run_start_next = now_reg;
                    end
                    run_valid_next = !done;
                    now_next       = now_plus;
                    pend0_next     = preempt ? beat_pre : beat_done;
                    pend1_next     = beat_done;
                    two_next       = preempt && done;
                    state_next     = (preempt || done) ? ST_EMIT : ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                if (push)
                begin
                    if (two_reg && !idx_reg)
                    begin
                        idx_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (push)
        begin
            out_next       = idx_reg ? pend1_reg : pend0_reg;
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            run_valid_reg <= 1'b0;
            run_slot_reg  <= '0;
            run_start_reg <= '0;
            now_reg       <= '0;
            two_reg       <= 1'b0;
            idx_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            run_valid_reg <= run_valid_next;
            run_slot_reg  <= run_slot_next;
            run_start_reg <= run_start_next;
            now_reg       <= now_next;
            two_reg       <= two_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg    <= req.operation;
            id_reg    <= req.job_id;
            burst_reg <= req.burst;
            lvl_reg   <= req.priority_level;
        end
        run_id_reg <= run_id_next;
        pend0_reg  <= pend0_next;
        pend1_reg  <= pend1_next;
        out_reg    <= out_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.job_id_out    = out_reg.id;
    assign rsp.segment_start = out_reg.seg_start;
    assign rsp.segment_end   = out_reg.seg_end;
    assign rsp.status        = out_reg.status;
    assign rsp.last          = out_reg.last;

endmodule

// ===== tb/srtf_tb_pkg.sv =====
`timescale 1ns / 1ps
// operation codes of the scheduler request beat, shared by the checker and the stimulus
// depends on nothing

package srtf_tb_pkg;

    typedef enum logic {
        OP_ARRIVAL = 1'b0,
        OP_TICK    = 1'b1
    } sched_op_t;

endpackage

// ===== tb/srtf_checker.sv =====
`timescale 1ns / 1ps
// scoreboard for the srtf scheduler core: mirrors the ready table, predicts result beats
// depends on srtf_pkg, srtf_tb_pkg and the channel interfaces in srtf_if

module srtf_checker #(
    parameter int SLOTS = srtf_pkg::SLOTS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    srtf_req_if  req,
    srtf_rsp_if  rsp,
    output int   mismatch_count,
    output int   beats_pending
);

    logic [srtf_pkg::ID_W-1:0]   job_tag  [SLOTS];
    logic [srtf_pkg::REM_W-1:0]  job_rem  [SLOTS];
    logic [srtf_pkg::LVL_W-1:0]  job_lvl  [SLOTS];
    bit                          job_live [SLOTS];
    int                          active_slot;
    bit                          active_live;
    logic [srtf_pkg::TIME_W-1:0] seg_origin;
    logic [srtf_pkg::TIME_W-1:0] sched_time;
    srtf_pkg::beat_t             segment_queue[$];

    initial
    begin
        mismatch_count = 0;
        beats_pending  = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic srtf_pkg::beat_t make_segment(input logic [srtf_pkg::ID_W-1:0] id,
                                                     input logic [srtf_pkg::TIME_W-1:0] from,
                                                     input logic [srtf_pkg::TIME_W-1:0] upto,
                                                     input srtf_pkg::status_t st);
        srtf_pkg::beat_t b;
        b.id        = id;
        b.seg_start = from;
        b.seg_end   = upto;
        b.status    = st;
        b.last      = 1'b0;
        return b;
    endfunction

    task automatic schedule_step(input srtf_tb_pkg::sched_op_t op,
                                 input logic [srtf_pkg::ID_W-1:0] id,
                                 input logic [srtf_pkg::REM_W-1:0] burst,
                                 input logic [srtf_pkg::LVL_W-1:0] lvl);
        srtf_pkg::beat_t fresh[$];
        srtf_pkg::beat_t b;
        int free_slot;
        int pick;
        free_slot = -1;
        pick      = -1;
        if (op == srtf_tb_pkg::OP_ARRIVAL)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (!job_live[i] && free_slot < 0)
                    free_slot = i;
            if (free_slot >= 0)
            begin
                job_tag[free_slot]  = id;
                job_rem[free_slot]  = burst;
                job_lvl[free_slot]  = lvl;
                job_live[free_slot] = 1'b1;
            end
            else
                fresh.push_back(make_segment(id, sched_time, sched_time,
                                             srtf_pkg::STATUS_REJECTED));
        end
        else
        begin
            // least remaining, then lower level, then lower slot
            for (int i = 0; i < SLOTS; i++)
                if (job_live[i] && (pick < 0 || job_rem[i] < job_rem[pick] ||
                    (job_rem[i] == job_rem[pick] && job_lvl[i] < job_lvl[pick])))
                    pick = i;
            if (pick < 0)
                sched_time++;
            else
            begin
                if (!active_live || active_slot != pick)
                begin
                    if (active_live)
                        fresh.push_back(make_segment(job_tag[active_slot], seg_origin,
                                                     sched_time, srtf_pkg::STATUS_PREEMPTED));
                    active_slot = pick;
                    active_live = 1'b1;
                    seg_origin  = sched_time;
                end
                if (job_rem[pick] != 0)
                    job_rem[pick]--;
                sched_time++;
                if (job_rem[pick] == 0)
                begin
                    fresh.push_back(make_segment(job_tag[pick], seg_origin, sched_time,
                                                 srtf_pkg::STATUS_COMPLETED));
                    job_live[pick] = 1'b0;
                    active_live    = 1'b0;
                end
            end
        end
        for (int k = 0; k < fresh.size(); k++)
        begin
            b      = fresh[k];
            b.last = (k == fresh.size() - 1);
            segment_queue.push_back(b);
        end
    endtask

    task automatic check_segment();
        srtf_pkg::beat_t want;
        if (segment_queue.size() == 0)
        begin
            report_mismatch($sformatf("unexpected beat id %0d [%0d,%0d] status %0d last %0d",
                                      rsp.job_id_out, rsp.segment_start, rsp.segment_end,
                                      rsp.status, rsp.last));
            return;
        end
        want = segment_queue.pop_front();
        if (rsp.job_id_out !== want.id || rsp.segment_start !== want.seg_start ||
            rsp.segment_end !== want.seg_end || rsp.status !== want.status ||
            rsp.last !== want.last)
            report_mismatch($sformatf(
                "want id %0d [%0d,%0d] st %0d last %0d, got id %0d [%0d,%0d] st %0d last %0d",
                want.id, want.seg_start, want.seg_end, want.status, want.last,
                rsp.job_id_out, rsp.segment_start, rsp.segment_end, rsp.status, rsp.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                job_live[i] = 1'b0;
            active_slot = 0;
            active_live = 1'b0;
            seg_origin  = '0;
            sched_time  = '0;
            segment_queue.delete();
            beats_pending <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                schedule_step(srtf_tb_pkg::sched_op_t'(req.operation), req.job_id,
                              req.burst, req.priority_level);
            if (rsp.valid && rsp.ready)
                check_segment();
            beats_pending <= segment_queue.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// top of the srtf scheduler bench: clock, reset, request stimulus and result back-pressure
// depends on srtf_pkg, srtf_tb_pkg, srtf_if, srtf_checker and the scheduler core

module testbench;

    localparam int SLOTS         = srtf_pkg::SLOTS_DEFAULT;
    // long receiver hold-off, enough for the block to fill and push back on requests
    localparam int HOLD_CYCLES   = 400;
    // settle time at the end, with plenty of margin over one item and its result beats
    localparam int SETTLE_CYCLES = 4 * SLOTS + 16;
    localparam int PHASE_ITEMS   = 400;

    logic clk;
    logic rst_n;

    // idling knobs, written only by the stimulus process
    int   req_idle_pct;
    int   rsp_stall_pct;
    bit   hold_request;

    int   mismatch_count;
    int   beats_pending;

    srtf_req_if req ();
    srtf_rsp_if rsp ();

    srtf_preemptive_scheduler_core #(
        .READY_SLOTS(SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    srtf_checker #(
        .SLOTS(SLOTS)
    ) sched_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .beats_pending  (beats_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // result side: random stalls per the current knob, plus one long hold-off when asked
    initial
    begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // offer one request beat and wait for it to be taken; random gaps go in front of it
    // valid stays high between back-to-back beats, so it never gets two updates in a step
    task automatic drive_item(input srtf_tb_pkg::sched_op_t op,
                              input logic [srtf_pkg::ID_W-1:0] id,
                              input logic [srtf_pkg::REM_W-1:0] burst,
                              input logic [srtf_pkg::LVL_W-1:0] lvl);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid          <= 1'b1;
        req.operation      <= op;
        req.job_id         <= id;
        req.burst          <= burst;
        req.priority_level <= lvl;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // stop offering and wait until every predicted result beat has come back
    task automatic drain_results();
        req.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (beats_pending != 0)
            @(posedge clk);
    endtask

    // random workload: batches of arrivals, then about enough ticks to work them off
    // an occasional big batch overfills the ready table and forces rejections
    task automatic run_workload(input int target);
        int sent;
        int batch;
        int work;
        int ticks;
        logic [srtf_pkg::REM_W-1:0] b;
        sent = 0;
        while (sent < target)
        begin
            batch = ($urandom_range(99) < 10) ? $urandom_range(8, 14) : $urandom_range(1, 5);
            work  = 0;
            repeat (batch)
            begin
                // short jobs mostly, so segments finish often; now and then a longer one
                b = srtf_pkg::REM_W'(($urandom_range(99) < 4) ? $urandom_range(11, 200)
                                                                : $urandom_range(1, 10));
                work += int'(b);
                drive_item(srtf_tb_pkg::OP_ARRIVAL, srtf_pkg::ID_W'($urandom_range(255)), b,
                           srtf_pkg::LVL_W'($urandom_range(15)));
            end
            ticks = $urandom_range(work / 2 + 1, work + 4);
            if (ticks > 40)
                ticks = 40;
            // tick beats carry junk in the fields the block must ignore
            repeat (ticks)
                drive_item(srtf_tb_pkg::OP_TICK, srtf_pkg::ID_W'($urandom),
                           srtf_pkg::REM_W'($urandom), srtf_pkg::LVL_W'($urandom));
            sent += batch + ticks;
        end
    endtask

    initial
    begin : stimulus
        int idle_by_phase  [4];
        int stall_by_phase [4];
        idle_by_phase  = '{0, 79, 0, 22};
        stall_by_phase = '{0, 0, 79, 22};

        req.valid          <= 1'b0;
        req.operation      <= srtf_tb_pkg::OP_ARRIVAL;
        req.job_id         <= '0;
        req.burst          <= '0;
        req.priority_level <= '0;
        req_idle_pct  = 0;
        rsp_stall_pct = 0;
        hold_request  = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle tick on an empty table: time moves, nothing comes out
        drive_item(srtf_tb_pkg::OP_TICK, 8'h5A, 16'h1234, 4'h7);
        // zero burst, id and level extremes, a remaining-time tie broken by level,
        // and a full tie broken by slot order (duplicate id too)
        drive_item(srtf_tb_pkg::OP_ARRIVAL, 8'h00, 16'h0000, 4'h0);
        drive_item(srtf_tb_pkg::OP_ARRIVAL, 8'hFF, 16'hFFFF, 4'hF);
        drive_item(srtf_tb_pkg::OP_ARRIVAL, 8'hAA, 16'd3, 4'h5);
        drive_item(srtf_tb_pkg::OP_ARRIVAL, 8'h55, 16'd3, 4'h2);
        drive_item(srtf_tb_pkg::OP_ARRIVAL, 8'h55, 16'd3, 4'h2);
        // zero-burst job starts after idle and completes on its first tick
        drive_item(srtf_tb_pkg::OP_TICK, 8'h00, 16'h0000, 4'h0);
        // lower level wins the tie and starts running
        drive_item(srtf_tb_pkg::OP_TICK, 8'hFF, 16'hFFFF, 4'hF);
        // a shorter arrival preempts it and completes at once: two beats from one tick
        drive_item(srtf_tb_pkg::OP_ARRIVAL, 8'h11, 16'd1, 4'h9);
        drive_item(srtf_tb_pkg::OP_TICK, 8'h00, 16'h0000, 4'h0);
        // fill the table; the wide bursts also walk the high burst bits
        drive_item(srtf_tb_pkg::OP_ARRIVAL, 8'h80, 16'h8000, 4'h0);
        drive_item(srtf_tb_pkg::OP_ARRIVAL, 8'h01, 16'h5555, 4'hA);
        drive_item(srtf_tb_pkg::OP_ARRIVAL, 8'h7F, 16'h2AAA, 4'h5);
        repeat (SLOTS - 7)
            drive_item(srtf_tb_pkg::OP_ARRIVAL, srtf_pkg::ID_W'($urandom_range(255)),
                       srtf_pkg::REM_W'($urandom_range(1, 8)),
                       srtf_pkg::LVL_W'($urandom_range(15)));
        // table full: this one is turned away
        drive_item(srtf_tb_pkg::OP_ARRIVAL, 8'h3C, 16'd4, 4'h3);
        drain_results();

        // random part, one phase per idling pattern; the first one also carries the
        // long receiver hold-off while requests keep coming
        for (int p = 0; p < 4; p++)
        begin
            req_idle_pct  = idle_by_phase[p];
            rsp_stall_pct = stall_by_phase[p];
            if (p == 0)
                hold_request = 1'b1;
            run_workload(PHASE_ITEMS);
            // sender goes quiet until every result is back
            drain_results();
        end

        rsp_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
